// ----- rtl/grid_reachability_check_defines.svh -----
// Assertion macros shared by the grid reachability check RTL.
// Included by modules that carry concurrent checks; depends on nothing.
`ifndef GRID_REACHABILITY_CHECK_DEFINES_SVH
`define GRID_REACHABILITY_CHECK_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GRC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("grc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define GRC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("grc assertion failed");

`endif

// ----- rtl/grc_pkg.sv -----
// Package for the grid reachability check: tile codes, register indexes,
// default sizes and the loader-to-engine event type. No dependencies.
package grc_pkg;

    localparam int TILE_W       = 8;
    localparam int CFG_W        = 7;
    localparam int CFG_ADDR_W   = 1;
    localparam int OUT_W        = 8;
    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    localparam logic [CFG_ADDR_W-1:0] REG_MAP_ROWS = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAP_COLS = 1'b1;
    localparam logic [CFG_W-1:0]      CFG_DIM_RESET = 7'd64;

    localparam logic [TILE_W-1:0] TILE_WALL      = 8'h31; // '1'
    localparam logic [TILE_W-1:0] TILE_FLOOR     = 8'h30; // '0'
    localparam logic [TILE_W-1:0] TILE_FILLED    = 8'h46; // 'F'
    localparam logic [TILE_W-1:0] TILE_EXIT      = 8'h45; // 'E'
    localparam logic [TILE_W-1:0] TILE_EXIT_SEEN = 8'h65; // 'e'
    localparam logic [TILE_W-1:0] TILE_START     = 8'h50; // 'P'

    // Loader -> engine events for one accepted item.
    typedef struct packed {
        logic wr;    // store the tile at the load position
        logic start; // last tile: begin fill and check
        logic found; // a start tile exists in this map
    } load_ev_t;

    // Tiles that are allowed once the fill is done.
    function automatic logic tile_ok(input logic [TILE_W-1:0] t);
        return (t == TILE_WALL) || (t == TILE_FILLED) ||
               (t == TILE_EXIT_SEEN) || (t == TILE_FLOOR);
    endfunction

endpackage

// ----- rtl/grc_loader.sv -----
// Load-position tracker: row/column counters, start capture, and a
// bit-serial divider that rebuilds row/column after a size change. Uses grc_pkg.
module grc_loader import grc_pkg::*; #(
    parameter int  MAX_ROWS = DEF_MAX_ROWS,
    parameter int  MAX_COLS = DEF_MAX_COLS,
    localparam int RW  = $clog2(MAX_ROWS),
    localparam int CW  = $clog2(MAX_COLS),
    localparam int RDW = $clog2(MAX_ROWS + 1),
    localparam int CDW = $clog2(MAX_COLS + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic              in_accept,
    input  logic [TILE_W-1:0] in_tile,
    input  logic              in_last,
    input  logic [RDW-1:0]    rows,
    input  logic [CDW-1:0]    cols,
    output logic              busy,
    output load_ev_t          ev,
    output logic [RW-1:0]     wr_row,
    output logic [CW-1:0]     wr_col,
    output logic [RW-1:0]     start_row,
    output logic [CW-1:0]     start_col
);

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int LPW   = $clog2(CELLS + 1);
    localparam int DCW   = $clog2(LPW + 1);

    typedef enum logic {L_RUN, L_DIV} ld_state_t;

    ld_state_t        state_reg;
    logic [LPW-1:0]   lp_reg;
    logic [LPW-1:0]   cells_reg;
    logic [RW-1:0]    row_reg;
    logic [CW-1:0]    col_reg;
    logic             found_reg;
    logic [RW-1:0]    srow_reg;
    logic [CW-1:0]    scol_reg;
    logic [LPW-1:0]   dvd_reg;
    logic [CDW-1:0]   rem_reg;
    logic [LPW-1:0]   quo_reg;
    logic [DCW-1:0]   cnt_reg;

    logic             in_range;
    logic             hit;
    logic             col_last;
    logic [CDW:0]     trial;
    logic             trial_ge;
    logic [CDW-1:0]   rem_step;
    logic [LPW-1:0]   quo_step;

    assign in_range = lp_reg < cells_reg;
    assign hit      = in_accept && in_range && (in_tile == TILE_START) && !found_reg;
    assign col_last = CDW'(col_reg) == (cols - CDW'(1));

    assign busy      = state_reg == L_DIV;
    assign ev.wr     = in_accept && in_range;
    assign ev.start  = in_accept && in_last;
    assign ev.found  = found_reg || hit;
    assign wr_row    = row_reg;
    assign wr_col    = col_reg;
    assign start_row = hit ? row_reg : srow_reg;
    assign start_col = hit ? col_reg : scol_reg;

    // one quotient bit per cycle: row = lp / cols, col = lp % cols
    assign trial    = {rem_reg, dvd_reg[LPW-1]};
    assign trial_ge = trial >= (CDW+1)'(cols);
    assign rem_step = trial_ge ? CDW'(trial - (CDW+1)'(cols)) : CDW'(trial);
    assign quo_step = {quo_reg[LPW-2:0], trial_ge};

    always_ff @(posedge aclk) begin
        cells_reg <= LPW'(rows) * LPW'(cols);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_DIV;
            cnt_reg   <= DCW'(LPW);
            lp_reg    <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            found_reg <= 1'b0;
            srow_reg  <= '0;
            scol_reg  <= '0;
            dvd_reg   <= '0;
            rem_reg   <= '0;
            quo_reg   <= '0;
        end else if (cfg_we) begin
            state_reg <= L_DIV;
            cnt_reg   <= DCW'(LPW);
            dvd_reg   <= lp_reg;
            rem_reg   <= '0;
            quo_reg   <= '0;
        end else begin
            unique case (state_reg)
                L_DIV: begin
                    dvd_reg <= {dvd_reg[LPW-2:0], 1'b0};
                    rem_reg <= rem_step;
                    quo_reg <= quo_step;
                    cnt_reg <= cnt_reg - DCW'(1);
                    if (cnt_reg == DCW'(1)) begin
                        row_reg   <= RW'(quo_step);
                        col_reg   <= CW'(rem_step);
                        state_reg <= L_RUN;
                    end
                end
                L_RUN: begin
                    if (in_accept && in_last) begin
                        lp_reg    <= '0;
                        row_reg   <= '0;
                        col_reg   <= '0;
                        found_reg <= 1'b0;
                    end else if (in_accept && in_range) begin
                        if (hit) begin
                            found_reg <= 1'b1;
                            srow_reg  <= row_reg;
                            scol_reg  <= col_reg;
                        end
                        lp_reg <= lp_reg + LPW'(1);
                        if (col_last) begin
                            col_reg <= '0;
                            row_reg <= row_reg + RW'(1);
                        end else begin
                            col_reg <= col_reg + CW'(1);
                        end
                    end
                end
                default: state_reg <= L_RUN;
            endcase
        end
    end

endmodule

// ----- rtl/grc_engine.sv -----
// Fill and check engine: grid store, fill stack and the sequencer that
// drives the grid write and read ports through fill and sweep. Uses grc_pkg and the defines header.
`include "grid_reachability_check_defines.svh"

module grc_engine import grc_pkg::*; #(
    parameter int  MAX_ROWS = DEF_MAX_ROWS,
    parameter int  MAX_COLS = DEF_MAX_COLS,
    localparam int RW  = $clog2(MAX_ROWS),
    localparam int CW  = $clog2(MAX_COLS),
    localparam int RDW = $clog2(MAX_ROWS + 1),
    localparam int CDW = $clog2(MAX_COLS + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  load_ev_t          ev,
    input  logic [RW-1:0]     start_row,
    input  logic [CW-1:0]     start_col,
    input  logic [RW-1:0]     ld_row,
    input  logic [CW-1:0]     ld_col,
    input  logic [TILE_W-1:0] ld_tile,
    input  logic [RDW-1:0]    rows,
    input  logic [CDW-1:0]    cols,
    input  logic              out_free,
    output logic              busy,
    output logic              res_valid,
    output logic              res_path
);

    localparam int AW         = RW + CW;
    localparam int GRID_DEPTH = MAX_ROWS * (2 ** CW);
    localparam int STK_DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int SPW        = $clog2(STK_DEPTH + 1);
    localparam int SIW        = $clog2(STK_DEPTH);

    localparam logic [1:0] NB_DOWN  = 2'd0;
    localparam logic [1:0] NB_UP    = 2'd1;
    localparam logic [1:0] NB_RIGHT = 2'd2;
    localparam logic [1:0] NB_LEFT  = 2'd3;

    typedef enum logic [3:0] {
        E_IDLE, E_PROBE, E_TEST, E_ADV, E_POP, E_LATCH, E_CHK, E_CHK_END, E_DONE
    } eng_state_t;

    logic [TILE_W-1:0] grid_mem [0:GRID_DEPTH-1];
    logic [AW-1:0]     stack_mem [0:STK_DEPTH-1];

    eng_state_t        state_reg;
    logic [SPW-1:0]    sp_reg;
    logic [1:0]        nb_reg;
    logic [RW:0]       cand_r_reg;
    logic [CW:0]       cand_c_reg;
    logic [RW-1:0]     cur_r_reg;
    logic [CW-1:0]     cur_c_reg;
    logic [RW-1:0]     chk_r_reg;
    logic [CW-1:0]     chk_c_reg;
    logic              chk_pend_reg;
    logic              ok_reg;
    logic [TILE_W-1:0] grid_rdata_reg;
    logic [AW-1:0]     stack_rdata_reg;

    logic              cand_in;
    logic [AW-1:0]     cand_addr;
    logic [AW-1:0]     chk_addr;
    logic [RW-1:0]     base_r;
    logic [CW-1:0]     base_c;
    logic [1:0]        gen_k;
    logic [RW:0]       gen_r;
    logic [CW:0]       gen_c;
    logic              blocked;
    logic              is_exit;
    logic              eng_we;
    logic              push;
    logic              chk_last;
    logic              ok_next;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [TILE_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;

    assign busy      = state_reg != E_IDLE;
    assign res_valid = state_reg == E_DONE;
    assign res_path  = ok_reg;

    assign cand_in   = (cand_r_reg != '0) && (cand_c_reg != '0) &&
                       (cand_r_reg < (RW+1)'(rows)) && (cand_c_reg < (CW+1)'(cols));
    assign cand_addr = {cand_r_reg[RW-1:0], cand_c_reg[CW-1:0]};
    assign chk_addr  = {chk_r_reg, chk_c_reg};
    assign chk_last  = ((RDW)'(chk_r_reg) == rows - RDW'(1)) &&
                       ((CDW)'(chk_c_reg) == cols - CDW'(1));

    // neighbor generator; a step below zero wraps high and fails the bound test
    assign base_r = (state_reg == E_LATCH) ? stack_rdata_reg[AW-1:CW] : cur_r_reg;
    assign base_c = (state_reg == E_LATCH) ? stack_rdata_reg[CW-1:0]  : cur_c_reg;
    assign gen_k  = (state_reg == E_LATCH) ? NB_DOWN : nb_reg + 2'd1;

    always_comb begin
        gen_r = {1'b0, base_r};
        gen_c = {1'b0, base_c};
        unique case (gen_k)
            NB_DOWN:  gen_r = {1'b0, base_r} + (RW+1)'(1);
            NB_UP:    gen_r = {1'b0, base_r} - (RW+1)'(1);
            NB_RIGHT: gen_c = {1'b0, base_c} + (CW+1)'(1);
            NB_LEFT:  gen_c = {1'b0, base_c} - (CW+1)'(1);
        endcase
    end

    assign blocked = (grid_rdata_reg == TILE_WALL) || (grid_rdata_reg == TILE_FILLED) ||
                     (grid_rdata_reg == TILE_EXIT_SEEN);
    assign is_exit = grid_rdata_reg == TILE_EXIT;
    assign eng_we  = (state_reg == E_TEST) && !blocked;
    assign push    = (state_reg == E_TEST) && !blocked && !is_exit;
    assign ok_next = ok_reg && (!chk_pend_reg || tile_ok(grid_rdata_reg));

    // shared grid write port: loader writes while idle, engine owns it while busy
    assign mem_we    = busy ? eng_we : ev.wr;
    assign mem_waddr = busy ? cand_addr : {ld_row, ld_col};
    assign mem_wdata = busy ? (is_exit ? TILE_EXIT_SEEN : TILE_FILLED) : ld_tile;
    assign mem_re    = ((state_reg == E_PROBE) && cand_in) || (state_reg == E_CHK);
    assign mem_raddr = (state_reg == E_PROBE) ? cand_addr : chk_addr;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            grid_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            grid_rdata_reg <= grid_mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            stack_mem[sp_reg[SIW-1:0]] <= cand_addr;
        end
        if (state_reg == E_POP) begin
            stack_rdata_reg <= stack_mem[SIW'(sp_reg - SPW'(1))];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= E_IDLE;
            sp_reg       <= '0;
            nb_reg       <= NB_DOWN;
            chk_pend_reg <= 1'b0;
            ok_reg       <= 1'b1;
        end else begin
            unique case (state_reg)
                E_IDLE: begin
                    if (ev.start) begin
                        sp_reg       <= '0;
                        ok_reg       <= 1'b1;
                        chk_pend_reg <= 1'b0;
                        chk_r_reg    <= '0;
                        chk_c_reg    <= '0;
                        // seed probe acts as the last neighbor of an empty pop
                        nb_reg       <= NB_LEFT;
                        cand_r_reg   <= {1'b0, start_row};
                        cand_c_reg   <= {1'b0, start_col};
                        state_reg    <= ev.found ? E_PROBE : E_CHK;
                    end
                end
                E_PROBE: begin
                    state_reg <= cand_in ? E_TEST : E_ADV;
                end
                E_TEST: begin
                    if (push) begin
                        sp_reg <= sp_reg + SPW'(1);
                    end
                    state_reg <= E_ADV;
                end
                E_ADV: begin
                    if (nb_reg == NB_LEFT) begin
                        state_reg <= (sp_reg == '0) ? E_CHK : E_POP;
                    end else begin
                        nb_reg     <= gen_k;
                        cand_r_reg <= gen_r;
                        cand_c_reg <= gen_c;
                        state_reg  <= E_PROBE;
                    end
                end
                E_POP: begin
                    sp_reg    <= sp_reg - SPW'(1);
                    state_reg <= E_LATCH;
                end
                E_LATCH: begin
                    cur_r_reg  <= base_r;
                    cur_c_reg  <= base_c;
                    nb_reg     <= NB_DOWN;
                    cand_r_reg <= gen_r;
                    cand_c_reg <= gen_c;
                    state_reg  <= E_PROBE;
                end
                E_CHK: begin
                    ok_reg       <= ok_next;
                    chk_pend_reg <= 1'b1;
                    if (chk_last) begin
                        state_reg <= E_CHK_END;
                    end else if ((CDW)'(chk_c_reg) == cols - CDW'(1)) begin
                        chk_c_reg <= '0;
                        chk_r_reg <= chk_r_reg + RW'(1);
                    end else begin
                        chk_c_reg <= chk_c_reg + CW'(1);
                    end
                end
                E_CHK_END: begin
                    ok_reg       <= ok_next;
                    chk_pend_reg <= 1'b0;
                    state_reg    <= E_DONE;
                end
                E_DONE: begin
                    if (out_free) begin
                        state_reg <= E_IDLE;
                    end
                end
                default: state_reg <= E_IDLE;
            endcase
        end
    end

    `GRC_ASSERT_IMPL(a_no_start_busy, aclk, aresetn, state_reg != E_IDLE, !ev.start)
    `GRC_ASSERT_IMPL(a_push_room, aclk, aresetn, push, sp_reg < SPW'(STK_DEPTH))
    `GRC_ASSERT_IMPL(a_done_stack_empty, aclk, aresetn, state_reg == E_DONE, sp_reg == '0)
    `GRC_ASSERT_NEXT(a_push_count, aclk, aresetn, push, sp_reg == $past(sp_reg) + SPW'(1))

endmodule

// ----- rtl/grid_reachability_check.sv -----
// Grid reachability check: tiles load one per cycle while s_tready is high; the last tile
// starts a 4-connected fill from the first 'P', then a sweep of every cell decides path_valid
// (one item per map). Each filled cell is popped and its four neighbors probed through the
// grid read port; s_tready is low while fill and sweep run and until the result moves out.
// Reset (aresetn low, synchronous) sets both size registers to 64 and clears the load state;
// then, as after any cfg write, s_tready stays low while the divider rebuilds row and column.
module grid_reachability_check import grc_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port: index 0 map_rows, index 1 map_cols
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    // tile stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TILE_W-1:0]     s_tdata,   // [7:0] tile
    input  logic                  s_tlast,   // last_tile
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata    // [0] path_valid, [7:1] zero
);

    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CW  = $clog2(MAX_COLS);
    localparam int RDW = $clog2(MAX_ROWS + 1);
    localparam int CDW = $clog2(MAX_COLS + 1);
    localparam int RXW = (RDW > CFG_W) ? RDW : CFG_W;
    localparam int CXW = (CDW > CFG_W) ? CDW : CFG_W;

    logic [CFG_W-1:0] map_rows_reg;
    logic [CFG_W-1:0] map_cols_reg;
    logic             m_tvalid_reg;
    logic             m_path_reg;

    logic [RXW-1:0]   rows_x;
    logic [CXW-1:0]   cols_x;
    logic [RDW-1:0]   rows_eff;
    logic [CDW-1:0]   cols_eff;
    logic             in_accept;
    logic             out_free;
    logic             ld_busy;
    logic             eng_busy;
    logic             res_valid;
    logic             res_path;
    load_ev_t         ld_ev;
    logic [RW-1:0]    ld_row;
    logic [CW-1:0]    ld_col;
    logic [RW-1:0]    start_row;
    logic [CW-1:0]    start_col;

    // size registers: zero acts as one, anything above the maximum as the maximum
    always_comb begin
        rows_x = RXW'(map_rows_reg);
        priority if (rows_x == '0) begin
            rows_x = RXW'(1);
        end else if (rows_x > RXW'(MAX_ROWS)) begin
            rows_x = RXW'(MAX_ROWS);
        end
        cols_x = CXW'(map_cols_reg);
        priority if (cols_x == '0) begin
            cols_x = CXW'(1);
        end else if (cols_x > CXW'(MAX_COLS)) begin
            cols_x = CXW'(MAX_COLS);
        end
        rows_eff = RDW'(rows_x);
        cols_eff = CDW'(cols_x);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_rows_reg <= CFG_DIM_RESET;
            map_cols_reg <= CFG_DIM_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_MAP_ROWS: map_rows_reg <= cfg_wdata;
                REG_MAP_COLS: map_cols_reg <= cfg_wdata;
            endcase
        end
    end

    // the next map may load while a result still waits in the output register
    assign s_tready  = !ld_busy && !eng_busy;
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= res_valid;
            m_path_reg   <= res_path;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_W-1){1'b0}}, m_path_reg};

    grc_loader #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_loader (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .in_accept (in_accept),
        .in_tile   (s_tdata),
        .in_last   (s_tlast),
        .rows      (rows_eff),
        .cols      (cols_eff),
        .busy      (ld_busy),
        .ev        (ld_ev),
        .wr_row    (ld_row),
        .wr_col    (ld_col),
        .start_row (start_row),
        .start_col (start_col)
    );

    grc_engine #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ev        (ld_ev),
        .start_row (start_row),
        .start_col (start_col),
        .ld_row    (ld_row),
        .ld_col    (ld_col),
        .ld_tile   (s_tdata),
        .rows      (rows_eff),
        .cols      (cols_eff),
        .out_free  (out_free),
        .busy      (eng_busy),
        .res_valid (res_valid),
        .res_path  (res_path)
    );

endmodule
